@@ src/lpfd_pkg.sv @@
// Shared types and constants for the length-prefixed frame deframer.
// No dependencies; imported by every module of the block.
`timescale 1ns / 1ps

package lpfd_pkg;

    // Frame layout
    localparam int unsigned HdrBytes     = 8;
    localparam int unsigned TrailerBytes = 2;
    localparam logic [31:0] MinFrameLen  = 32'd10;
    localparam logic [31:0] MaxLenReset  = 32'd65535;

    // Header byte index that completes the length field and the header
    localparam logic [2:0]  HdrLastLenIdx = 3'd3;
    localparam logic [2:0]  HdrLastIdx    = 3'(HdrBytes - 1);

    // Deframer phase
    typedef enum logic [1:0] {
        PH_HEADER  = 2'd0,
        PH_PAYLOAD = 2'd1,
        PH_TRAILER = 2'd2
    } t_phase;

    // One result request
    typedef struct packed {
        logic [7:0]  payload_byte;
        logic [31:0] message_type;
        logic        has_payload;
        logic        last_of_frame;
        logic        length_error;
    } t_result;

endpackage

@@ src/length_prefixed_frame_deframer_core.sv @@
// Results are registered: each is written into the output buffer at the edge that accepts its byte.
// Throughput: one byte per cycle while the input stall is low; the two-entry output
//   buffer takes a new byte while an earlier result is still held by the output stall.
// Input stall rises only when both buffer entries hold results.
// Reset (synchronous, active low) returns to header collection, empties the buffer
//   and sets the maximum frame length to 65535.
`timescale 1ns / 1ps

module length_prefixed_frame_deframer_core
    import lpfd_pkg::*;
(
    input  logic        i_clk,
    input  logic        i_rst_n,
    // configuration
    input  logic        i_cfg_wr_en,
    input  logic [31:0] i_cfg_wr_data,
    // byte input
    input  logic        i_in_valid,
    output logic        o_in_stall,
    input  logic [7:0]  i_data_byte,
    // result output
    output logic        o_out_valid,
    input  logic        i_out_stall,
    output logic [7:0]  o_payload_byte,
    output logic [31:0] o_message_type,
    output logic        o_has_payload,
    output logic        o_last_of_frame,
    output logic        o_length_error
);

    logic [31:0] r_max_len;
    logic        full;
    logic        fire;
    logic        res_valid;
    t_result     res;
    t_result     out_res;

    // Maximum frame length register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n)
            r_max_len <= MaxLenReset;
        else if (i_cfg_wr_en)
            r_max_len <= i_cfg_wr_data;
    end

    assign o_in_stall = full;
    assign fire       = i_in_valid && !full;

    lpfd_parser u_parser (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_fire      (fire),
        .i_data_byte (i_data_byte),
        .i_max_len   (r_max_len),
        .o_res_valid (res_valid),
        .o_res       (res)
    );

    lpfd_out_buf u_out_buf (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (fire && res_valid),
        .i_res   (res),
        .i_stall (i_out_stall),
        .o_full  (full),
        .o_valid (o_out_valid),
        .o_res   (out_res)
    );

    assign o_payload_byte  = out_res.payload_byte;
    assign o_message_type  = out_res.message_type;
    assign o_has_payload   = out_res.has_payload;
    assign o_last_of_frame = out_res.last_of_frame;
    assign o_length_error  = out_res.length_error;

endmodule

@@ src/lpfd_parser.sv @@
// Byte-level frame parser: header collection, payload count, trailer skip.
// Depends on lpfd_pkg; feeds at most one result per accepted byte to lpfd_out_buf.
`timescale 1ns / 1ps

module lpfd_parser
    import lpfd_pkg::*;
(
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_fire,
    input  logic [7:0]  i_data_byte,
    input  logic [31:0] i_max_len,
    output logic        o_res_valid,
    output t_result     o_res
);

    t_phase      r_phase,  n_phase;
    logic [2:0]  r_hdr_cnt, n_hdr_cnt;
    logic [31:0] r_len,    n_len;
    logic [31:0] r_type,   n_type;
    logic [31:0] r_remain, n_remain;
    logic [31:0] dec_remain;

    assign dec_remain = r_remain - 32'd1;

    // Next state and result for the byte on the input
    always_comb begin
        n_phase     = r_phase;
        n_hdr_cnt   = r_hdr_cnt;
        n_len       = r_len;
        n_type      = r_type;
        n_remain    = r_remain;
        o_res_valid = 1'b0;
        o_res       = '{payload_byte: 8'd0, message_type: r_type, has_payload: 1'b0,
                        last_of_frame: 1'b0, length_error: 1'b0};
        unique case (r_phase)
            PH_PAYLOAD: begin
                n_remain                 = dec_remain;
                o_res_valid              = 1'b1;
                o_res.payload_byte       = i_data_byte;
                o_res.has_payload        = 1'b1;
                o_res.last_of_frame      = (dec_remain == 32'd0);
                if (dec_remain == 32'd0) begin
                    n_phase  = PH_TRAILER;
                    n_remain = 32'(TrailerBytes);
                end
            end
            PH_TRAILER: begin
                n_remain = dec_remain;
                if (dec_remain == 32'd0) begin
                    n_phase   = PH_HEADER;
                    n_hdr_cnt = 3'd0;
                    // empty frame marker
                    if (r_len == MinFrameLen) begin
                        o_res_valid         = 1'b1;
                        o_res.last_of_frame = 1'b1;
                    end
                end
            end
            default: begin
                // header collection; unused code lands here too
                n_phase = PH_HEADER;
                if (r_hdr_cnt <= HdrLastLenIdx)
                    n_len[{r_hdr_cnt[1:0], 3'b000} +: 8] = i_data_byte;
                else
                    n_type[{r_hdr_cnt[1:0], 3'b000} +: 8] = i_data_byte;
                if (r_hdr_cnt != HdrLastIdx) begin
                    n_hdr_cnt = r_hdr_cnt + 3'd1;
                end else begin
                    n_hdr_cnt          = 3'd0;
                    o_res.message_type = n_type;
                    if (r_len < MinFrameLen || r_len > i_max_len) begin
                        o_res_valid        = 1'b1;
                        o_res.length_error = 1'b1;
                    end else if (r_len == MinFrameLen) begin
                        n_phase  = PH_TRAILER;
                        n_remain = 32'(TrailerBytes);
                    end else begin
                        n_phase  = PH_PAYLOAD;
                        n_remain = r_len - MinFrameLen;
                    end
                end
            end
        endcase
    end

    // State registers advance only on an accepted byte
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_phase   <= PH_HEADER;
            r_hdr_cnt <= 3'd0;
            r_len     <= 32'd0;
            r_type    <= 32'd0;
            r_remain  <= 32'd0;
        end else if (i_fire) begin
            r_phase   <= n_phase;
            r_hdr_cnt <= n_hdr_cnt;
            r_len     <= n_len;
            r_type    <= n_type;
            r_remain  <= n_remain;
        end
    end

    // Payload phase always has bytes left to deliver
    a_payload_nonzero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_phase == PH_PAYLOAD |-> r_remain != 32'd0)
        else $error("payload phase with zero bytes remaining");

    // An error result never carries data or a frame end
    a_err_clean: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_res_valid && o_res.length_error) |-> (!o_res.has_payload && !o_res.last_of_frame))
        else $error("length error result carries payload or last flag");

    // Trailer countdown never exceeds the trailer length
    a_trailer_cnt: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_phase == PH_TRAILER |-> (r_remain != 32'd0 && r_remain <= 32'(TrailerBytes)))
        else $error("trailer counter out of range");

endmodule

@@ src/lpfd_out_buf.sv @@
// Two-entry result buffer that decouples parser from the output stall.
// Depends on lpfd_pkg for the result request type.
`timescale 1ns / 1ps

module lpfd_out_buf
    import lpfd_pkg::*;
(
    input  logic    i_clk,
    input  logic    i_rst_n,
    input  logic    i_push,
    input  t_result i_res,
    input  logic    i_stall,
    output logic    o_full,
    output logic    o_valid,
    output t_result o_res
);

    t_result    r_mem [2];
    logic       r_wptr, r_rptr;
    logic [1:0] r_count;
    logic       pop;

    assign o_valid = (r_count != 2'd0);
    assign o_full  = (r_count == 2'd2);
    assign pop     = o_valid && !i_stall;
    assign o_res   = r_mem[r_rptr];

    // Storage
    always_ff @(posedge i_clk) begin
        if (i_push)
            r_mem[r_wptr] <= i_res;
    end

    // Pointers and fill count
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wptr  <= 1'b0;
            r_rptr  <= 1'b0;
            r_count <= 2'd0;
        end else begin
            if (i_push)
                r_wptr <= ~r_wptr;
            if (pop)
                r_rptr <= ~r_rptr;
            r_count <= r_count + {1'b0, i_push} - {1'b0, pop};
        end
    end

endmodule

@@ tb/sv/length_prefixed_frame_deframer_core_test.sv @@
// Self-checking test for the length-prefixed frame deframer core.
// Depends on lpfd_pkg and length_prefixed_frame_deframer_core; a class predicts
// the results of each accepted byte, and tasks drive framed streams and config.
`timescale 1ns / 1ps

module length_prefixed_frame_deframer_core_test
    import lpfd_pkg::*;
;

    localparam int          QuietLimit  = 5000;
    localparam int          PhaseBytes  = 160;
    localparam int          MaxGap      = 300;
    localparam int          NoiseMaxLen = 300;
    localparam logic [31:0] AllOnes     = 32'hFFFF_FFFF;

    // Predicts deframer results byte by byte and checks the output against them
    class frame_scoreboard;
        t_phase      ph;
        logic [2:0]  hdr_idx;
        logic [31:0] frame_len;
        logic [31:0] frame_type;
        logic [31:0] remaining;
        logic [31:0] max_len;
        t_result     pending_results[$];
        int          errors;
        int          n_payload;
        int          n_markers;
        int          n_len_errors;

        function new();
            ph         = PH_HEADER;
            hdr_idx    = '0;
            frame_len  = '0;
            frame_type = '0;
            remaining  = '0;
            max_len    = MaxLenReset;
            errors     = 0;
            n_payload  = 0;
            n_markers  = 0;
            n_len_errors = 0;
        endfunction

        function void push_result(logic [7:0] b, logic has, logic last, logic err);
            t_result r;
            r.payload_byte  = b;
            r.message_type  = frame_type;
            r.has_payload   = has;
            r.last_of_frame = last;
            r.length_error  = err;
            pending_results = {pending_results, r};
        endfunction

        // Advance the frame state by one accepted byte request
        function void note_stream_byte(logic [7:0] b);
            case (ph)
                PH_PAYLOAD: begin
                    remaining = remaining - 32'd1;
                    push_result(b, 1'b1, remaining == 0, 1'b0);
                    n_payload++;
                    if (remaining == 0) begin
                        ph        = PH_TRAILER;
                        remaining = TrailerBytes;
                    end
                end
                PH_TRAILER: begin
                    remaining = remaining - 32'd1;
                    if (remaining == 0) begin
                        ph      = PH_HEADER;
                        hdr_idx = '0;
                        // empty payload: marker on the final trailer byte
                        if (frame_len == MinFrameLen) begin
                            push_result(8'd0, 1'b0, 1'b1, 1'b0);
                            n_markers++;
                        end
                    end
                end
                default: begin
                    // header: length then type, both little endian
                    ph = PH_HEADER;
                    if (hdr_idx <= HdrLastLenIdx)
                        frame_len[{hdr_idx[1:0], 3'b000} +: 8] = b;
                    else
                        frame_type[{hdr_idx[1:0], 3'b000} +: 8] = b;
                    if (hdr_idx != HdrLastIdx) begin
                        hdr_idx = hdr_idx + 3'd1;
                    end else begin
                        hdr_idx = '0;
                        if (frame_len < MinFrameLen || frame_len > max_len) begin
                            push_result(8'd0, 1'b0, 1'b0, 1'b1);
                            n_len_errors++;
                        end else if (frame_len == MinFrameLen) begin
                            ph        = PH_TRAILER;
                            remaining = TrailerBytes;
                        end else begin
                            ph        = PH_PAYLOAD;
                            remaining = frame_len - MinFrameLen;
                        end
                    end
                end
            endcase
        endfunction

        function void report_field(string name, logic [31:0] want, logic [31:0] got);
            $display("%0t: %s mismatch, expected 0x%0h, got 0x%0h", $time, name, want, got);
            errors++;
        endfunction

        // Compare one accepted result request with the oldest prediction
        function void check_result(t_result got);
            t_result want;
            if (pending_results.size() == 0) begin
                $display("%0t: unexpected result, expected none, got byte 0x%0h type 0x%0h %b%b%b",
                         $time, got.payload_byte, got.message_type, got.has_payload,
                         got.last_of_frame, got.length_error);
                errors++;
                return;
            end
            want = pending_results.pop_front();
            if (got.payload_byte !== want.payload_byte)
                report_field("payload_byte", 32'(want.payload_byte), 32'(got.payload_byte));
            if (got.message_type !== want.message_type)
                report_field("message_type", want.message_type, got.message_type);
            if (got.has_payload !== want.has_payload)
                report_field("has_payload", 32'(want.has_payload), 32'(got.has_payload));
            if (got.last_of_frame !== want.last_of_frame)
                report_field("last_of_frame", 32'(want.last_of_frame),
                             32'(got.last_of_frame));
            if (got.length_error !== want.length_error)
                report_field("length_error", 32'(want.length_error), 32'(got.length_error));
        endfunction

        function bit at_frame_start();
            return ph == PH_HEADER && hdr_idx == 0;
        endfunction

        function int pending();
            return pending_results.size();
        endfunction
    endclass

    logic        i_clk         = 1'b0;
    logic        i_rst_n       = 1'b0;
    logic        i_cfg_wr_en   = 1'b0;
    logic [31:0] i_cfg_wr_data = '0;
    logic        i_in_valid    = 1'b0;
    logic        o_in_stall;
    logic [7:0]  i_data_byte   = '0;
    logic        o_out_valid;
    logic        i_out_stall   = 1'b0;
    logic [7:0]  o_payload_byte;
    logic [31:0] o_message_type;
    logic        o_has_payload;
    logic        o_last_of_frame;
    logic        o_length_error;

    frame_scoreboard frames;
    int send_idle_pct = 0;
    int stall_pct     = 0;
    int bytes_sent    = 0;
    int n_settings    = 0;
    int quiet_cycles  = 0;

    length_prefixed_frame_deframer_core dut (
        .i_clk           (i_clk),
        .i_rst_n         (i_rst_n),
        .i_cfg_wr_en     (i_cfg_wr_en),
        .i_cfg_wr_data   (i_cfg_wr_data),
        .i_in_valid      (i_in_valid),
        .o_in_stall      (o_in_stall),
        .i_data_byte     (i_data_byte),
        .o_out_valid     (o_out_valid),
        .i_out_stall     (i_out_stall),
        .o_payload_byte  (o_payload_byte),
        .o_message_type  (o_message_type),
        .o_has_payload   (o_has_payload),
        .o_last_of_frame (o_last_of_frame),
        .o_length_error  (o_length_error)
    );

    always #5 i_clk = ~i_clk;

    // Random output stall
    always @(posedge i_clk) begin
        i_out_stall <= ($urandom_range(99) < stall_pct);
    end

    // Check each result request taken by the receiver
    always @(posedge i_clk) begin : result_monitor
        t_result got;
        if (i_rst_n && o_out_valid && !i_out_stall) begin
            got.payload_byte  = o_payload_byte;
            got.message_type  = o_message_type;
            got.has_payload   = o_has_payload;
            got.last_of_frame = o_last_of_frame;
            got.length_error  = o_length_error;
            frames.check_result(got);
        end
    end

    // Watchdog: ends the run when no request moves for too long
    always @(posedge i_clk) begin
        if ((i_in_valid && !o_in_stall) || (o_out_valid && !i_out_stall))
            quiet_cycles <= 0;
        else
            quiet_cycles <= quiet_cycles + 1;
        if (quiet_cycles >= QuietLimit) begin
            $display("%0t: watchdog, no request moved for %0d cycles", $time, quiet_cycles);
            $display("FAILURE");
            $finish;
        end
    end

    // Send one byte request, with a random idle gap ahead of it; valid stays high
    // on return, so the caller must drive the next byte or lower valid in the same step
    task automatic send_byte(input logic [7:0] b);
        int gap;
        gap = 0;
        while (gap < MaxGap && $urandom_range(99) < send_idle_pct)
            gap++;
        if (gap > 0) begin
            i_in_valid <= 1'b0;
            repeat (gap) @(posedge i_clk);
        end
        i_in_valid  <= 1'b1;
        i_data_byte <= b;
        do @(posedge i_clk); while (o_in_stall);
        frames.note_stream_byte(b);
        bytes_sent++;
    endtask

    task automatic send_word(input logic [31:0] w);
        for (int i = 0; i < 4; i++)
            send_byte(w[8*i +: 8]);
    endtask

    // Header, then payload and trailer only when the length is accepted
    task automatic send_frame(input logic [31:0] len, input logic [31:0] typ);
        send_word(len);
        send_word(typ);
        if (len >= MinFrameLen && len <= frames.max_len)
            repeat (len - MinFrameLen + TrailerBytes) send_byte(8'($urandom));
    endtask

    // Write the maximum length once the block has drained
    task automatic set_max_length(input logic [31:0] v);
        i_in_valid <= 1'b0;
        while (frames.pending() != 0) @(posedge i_clk);
        repeat (4) @(posedge i_clk);
        i_cfg_wr_en   <= 1'b1;
        i_cfg_wr_data <= v;
        @(posedge i_clk);
        i_cfg_wr_en <= 1'b0;
        frames.max_len = v;
        n_settings++;
    endtask

    // Mostly well-formed frames; some length errors and raw noise bursts
    task automatic send_random_item();
        int          sel;
        logic [31:0] len;
        logic [31:0] typ;
        logic [31:0] hi;
        sel = $urandom_range(99);
        typ = $urandom;
        case ($urandom_range(7))
            0: typ = '0;
            1: typ = AllOnes;
            default: ;
        endcase
        if (sel < 70 && frames.max_len >= MinFrameLen) begin
            hi = ($urandom_range(9) == 0) ? 32'd200 : 32'd40;
            if (frames.max_len < hi)
                hi = frames.max_len;
            len = $urandom_range(hi, MinFrameLen);
            send_frame(len, typ);
        end else if (sel < 85 || frames.max_len > NoiseMaxLen) begin
            if (frames.max_len == AllOnes || $urandom_range(1) == 0)
                len = $urandom_range(MinFrameLen - 1, 0);
            else if ($urandom_range(1) == 0)
                len = frames.max_len + 1 + $urandom_range(20, 0) % (AllOnes - frames.max_len);
            else
                len = frames.max_len + 1 + ($urandom % (AllOnes - frames.max_len));
            send_frame(len, typ);
        end else begin
            // noise, then run on until the stream is back at a header boundary
            repeat ($urandom_range(12, 1)) send_byte(8'($urandom));
            while (!frames.at_frame_start())
                send_byte(8'($urandom));
        end
    endtask

    task automatic run_setting(input logic [31:0] max_len, input int s_pct, input int r_pct);
        int start;
        set_max_length(max_len);
        send_idle_pct = s_pct;
        stall_pct     = r_pct;
        start         = bytes_sent;
        while (bytes_sent - start < PhaseBytes)
            send_random_item();
    endtask

    initial begin
        frames = new();
        repeat (5) @(posedge i_clk);
        i_rst_n <= 1'b1;

        // Directed: empty frame marker, short length error, one-byte payload
        send_frame(MinFrameLen, AllOnes);
        send_frame(32'd0, AllOnes);
        send_word(32'd11);
        send_word(32'd0);
        send_byte(8'hFF);
        send_byte(8'h00);
        send_byte(8'hFF);

        // Random frames over several register values and idling patterns
        run_setting(MaxLenReset, 0, 0);
        run_setting(MinFrameLen, 88, 0);
        run_setting(AllOnes, 0, 88);
        run_setting(MinFrameLen - 1, 15, 15);
        run_setting($urandom_range(NoiseMaxLen, 11), 0, 0);
        run_setting($urandom_range(64, MinFrameLen), 15, 15);
        run_setting(32'd0, 0, 0);
        run_setting(MaxLenReset, 15, 15);

        i_in_valid <= 1'b0;
        while (frames.pending() != 0) @(posedge i_clk);
        repeat (10) @(posedge i_clk);

        $display("Covered %0d stream bytes over %0d max-length settings:", bytes_sent,
                 n_settings);
        $display("  %0d payload bytes, %0d empty frames, %0d length errors, %0d mismatches",
                 frames.n_payload, frames.n_markers, frames.n_len_errors, frames.errors);
        if (frames.errors == 0 && frames.pending() == 0) begin
            $display("SUCCESS");
        end else begin
            $display("FAILURE");
        end
        $finish;
    end

endmodule
